// File: rtl/vets_pkg.sv
package vets_pkg;

   // Field widths fixed by the interface
   localparam int ACTION_W      = 2;
   localparam int WEEK_W        = 12;
   localparam int SECOND_W      = 36;
   localparam int TIME_W        = 48;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_INDEX_W = 12;
   localparam int BAD_W         = 2;

   // Week length in seconds and the product width of week * seconds
   localparam int WEEK_SECONDS_W = 20;
   localparam logic [WEEK_SECONDS_W-1:0] WEEK_SECONDS = WEEK_SECONDS_W'(604800);
   localparam int PRODUCT_W     = WEEK_W + WEEK_SECONDS_W;
   localparam int MAX_FRACTION_BITS = 24;

   // Defaults for the top-level parameters
   localparam int DEFAULT_TABLE_DEPTH   = 4096;
   localparam int DEFAULT_FRACTION_BITS = 16;

   // Request action codes
   localparam logic [ACTION_W-1:0] ACTION_CLEAR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_APPEND = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_QUERY  = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_FOUND  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BEFORE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_AFTER  = 2'd3;

   // One table record: bit 0 of bad is the first flag, bit 1 the second
   typedef struct packed {
      logic [BAD_W-1:0]  bad;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   // Outcome of one probe through the shared compare unit
   typedef struct packed {
      logic valid;
      logic less;
      logic equal;
   } cmp_result_type;

endpackage

// File: rtl/vets_table.sv
module vets_table import vets_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   localparam int IndexW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IndexW-1:0] wr_addr,
   input  entry_type         wr_entry,
   input  logic [IndexW-1:0] rd_addr,
   output entry_type         rd_entry
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_entry_ff;

   // Write one record per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   // Read one record per cycle, data registered
   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// File: rtl/vets_cmp.sv
module vets_cmp import vets_pkg::*; (
   input  logic              validity_mode,
   input  entry_type         entry,
   input  logic [TIME_W-1:0] query_time,
   output cmp_result_type    result
);

   // Classify the record and compare its time against the query
   always_comb begin
      if (validity_mode) begin
         result.valid = !entry.bad[0];
      end else begin
         result.valid = !(entry.bad[0] && entry.bad[1]);
      end
      result.less  = query_time < entry.stamp;
      result.equal = query_time == entry.stamp;
   end

endmodule

// File: rtl/valid_entry_time_search.sv
// Time-ordered record table with a search that skips invalid records.
// A request is taken when start is high and busy is low; busy stays high until
// the request is done. Clear and unused actions complete in the request cycle
// itself. An append passes through the request cycle, a multiply state and a
// state that adds and writes the table. An append to a full table is dropped
// in the request cycle. A query reports one response, a single-cycle rsp_valid
// strobe that the receiver must take as it comes; the strobe falls in the first
// idle cycle, so the next request can be taken alongside it. The query time is
// set by the records visited after the request cycle: a table read and a
// compare in the shared compare unit per record in the scans for the first and
// last valid records, a bound check, a read and a compare per binary-search
// step plus one final bound check, a read and a compare per invalid record
// stepped over upward, and a bound check, a read and a compare per record
// stepped over downward. A query can end early on an exact match.
// validity_mode is written through the csr channel, which is always ready; the
// user must write it only while the block is idle, unenforced by the block.
module valid_entry_time_search import vets_pkg::*; #(
   parameter int TABLE_DEPTH   = DEFAULT_TABLE_DEPTH,
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [ACTION_W-1:0]      req_action,
   input  logic [WEEK_W-1:0]        req_entry_week,
   input  logic [SECOND_W-1:0]      req_entry_second,
   input  logic                     req_first_bad,
   input  logic                     req_second_bad,
   input  logic [TIME_W-1:0]        req_query_time,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ENTRY_INDEX_W-1:0] rsp_entry_index,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);

   localparam int IndexW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CountW = $clog2(TABLE_DEPTH + 1);
   localparam int ShiftW = PRODUCT_W + MAX_FRACTION_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_APP_MUL,
      S_APP_WR,
      S_HEAD_CHK,
      S_HEAD_EV,
      S_TAIL_RD,
      S_TAIL_EV,
      S_LOOP,
      S_UP_RD,
      S_UP_EV,
      S_DN_CHK,
      S_DN_RD,
      S_DN_EV
   } state_type;

   state_type                  state_ff, state_in;
   logic [CountW-1:0]          count_ff, count_in;
   logic                       mode_ff, mode_in;
   logic [CountW-1:0]          head_ff, head_in;
   logic [CountW-1:0]          tail_ff, tail_in;
   logic [CountW-1:0]          mid_ff, mid_in;
   logic [CountW-1:0]          probe_ff, probe_in;
   logic [TIME_W-1:0]          query_ff, query_in;
   logic [WEEK_W-1:0]          week_ff, week_in;
   logic [SECOND_W-1:0]        second_ff, second_in;
   logic [BAD_W-1:0]           bad_ff, bad_in;
   logic [PRODUCT_W-1:0]       product_ff, product_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [ENTRY_INDEX_W-1:0]   rsp_index_ff, rsp_index_in;

   logic                       accept;
   logic [CountW:0]            bound_sum;
   logic [CountW-1:0]          mid_calc;
   logic [ShiftW-1:0]          week_shifted;
   logic                       wr_en;
   entry_type                  wr_entry;
   entry_type                  rd_entry;
   cmp_result_type             cmp;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // Midpoint of the current search bounds
   assign bound_sum = {1'b0, head_ff} + {1'b0, tail_ff};
   assign mid_calc  = bound_sum[CountW:1];

   // Form the record time: week * 604800 scaled to fixed point plus seconds
   assign week_shifted   = {{MAX_FRACTION_BITS{1'b0}}, product_ff} << FRACTION_BITS;
   assign wr_entry.stamp = TIME_W'(week_shifted) + TIME_W'(second_ff);
   assign wr_entry.bad   = bad_ff;
   assign wr_en          = (state_ff == S_APP_WR);

   vets_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[IndexW-1:0]),
      .wr_entry (wr_entry),
      .rd_addr  (probe_ff[IndexW-1:0]),
      .rd_entry (rd_entry)
   );

   vets_cmp u_cmp (
      .validity_mode (mode_ff),
      .entry         (rd_entry),
      .query_time    (query_ff),
      .result        (cmp)
   );

   // Sequence requests and search steps
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      mid_in        = mid_ff;
      probe_in      = probe_ff;
      query_in      = query_ff;
      week_in       = week_ff;
      second_in     = second_ff;
      bad_in        = bad_ff;
      product_in    = product_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;

      if (csr_valid && csr_ready) begin
         mode_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               week_in   = req_entry_week;
               second_in = req_entry_second;
               bad_in    = {req_second_bad, req_first_bad};
               query_in  = req_query_time;
               probe_in  = '0;
               case (req_action)
                  ACTION_CLEAR: begin
                     count_in = '0;
                  end
                  ACTION_APPEND: begin
                     if (count_ff < CountW'(TABLE_DEPTH)) begin
                        state_in = S_APP_MUL;
                     end
                  end
                  ACTION_QUERY: begin
                     state_in = S_HEAD_CHK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_APP_MUL: begin
            product_in = PRODUCT_W'(week_ff) * PRODUCT_W'(WEEK_SECONDS);
            state_in   = S_APP_WR;
         end
         S_APP_WR: begin
            count_in = count_ff + 1'b1;
            state_in = S_IDLE;
         end
         // Scan upward for the first valid record
         S_HEAD_CHK: begin
            if (probe_ff >= count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NONE;
               rsp_index_in  = '0;
               state_in      = S_IDLE;
            end else begin
               state_in = S_HEAD_EV;
            end
         end
         S_HEAD_EV: begin
            if (!cmp.valid) begin
               probe_in = probe_ff + 1'b1;
               state_in = S_HEAD_CHK;
            end else if (cmp.less) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_BEFORE;
               rsp_index_in  = '0;
               state_in      = S_IDLE;
            end else begin
               head_in  = probe_ff;
               probe_in = count_ff - 1'b1;
               state_in = S_TAIL_RD;
            end
         end
         // Scan downward for the last valid record
         S_TAIL_RD: begin
            state_in = S_TAIL_EV;
         end
         S_TAIL_EV: begin
            if (!cmp.valid) begin
               probe_in = probe_ff - 1'b1;
               state_in = S_TAIL_RD;
            end else if (!cmp.less && !cmp.equal) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_AFTER;
               rsp_index_in  = '0;
               state_in      = S_IDLE;
            end else begin
               tail_in  = probe_ff;
               state_in = S_LOOP;
            end
         end
         // Start a probe at the midpoint, or finish on the upper bound
         S_LOOP: begin
            if (tail_ff - head_ff > CountW'(1)) begin
               mid_in   = mid_calc;
               probe_in = mid_calc;
               state_in = S_UP_RD;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_FOUND;
               rsp_index_in  = ENTRY_INDEX_W'(tail_ff);
               state_in      = S_IDLE;
            end
         end
         S_UP_RD: begin
            state_in = S_UP_EV;
         end
         S_UP_EV: begin
            if (cmp.valid) begin
               if (cmp.equal) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FOUND;
                  rsp_index_in  = ENTRY_INDEX_W'(probe_ff);
                  state_in      = S_IDLE;
               end else begin
                  if (cmp.less) begin
                     tail_in = probe_ff;
                  end else begin
                     head_in = probe_ff;
                  end
                  state_in = S_LOOP;
               end
            end else if (tail_ff - probe_ff > CountW'(1)) begin
               probe_in = probe_ff + 1'b1;
               state_in = S_UP_RD;
            end else begin
               probe_in = mid_ff;
               state_in = S_DN_CHK;
            end
         end
         // Probe downward from the midpoint
         S_DN_CHK: begin
            if (probe_ff - head_ff > CountW'(1)) begin
               probe_in = probe_ff - 1'b1;
               state_in = S_DN_RD;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_FOUND;
               rsp_index_in  = ENTRY_INDEX_W'(tail_ff);
               state_in      = S_IDLE;
            end
         end
         S_DN_RD: begin
            state_in = S_DN_EV;
         end
         S_DN_EV: begin
            if (cmp.valid) begin
               if (cmp.equal) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FOUND;
                  rsp_index_in  = ENTRY_INDEX_W'(probe_ff);
                  state_in      = S_IDLE;
               end else begin
                  if (cmp.less) begin
                     tail_in = probe_ff;
                  end else begin
                     head_in = probe_ff;
                  end
                  state_in = S_LOOP;
               end
            end else begin
               state_in = S_DN_CHK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         mode_ff       <= mode_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         mid_ff        <= mid_in;
         probe_ff      <= probe_in;
         query_ff      <= query_in;
         week_ff       <= week_in;
         second_ff     <= second_in;
         bad_ff        <= bad_in;
         product_ff    <= product_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;

`ifndef ASSERT_OFF
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe lasted more than one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(TABLE_DEPTH))
      else $error("record count beyond table depth");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_FOUND) |-> rsp_entry_index == '0)
      else $error("nonzero index on a not-found response");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACTION_QUERY) |=> busy && !rsp_valid)
      else $error("query did not hold the block busy");

   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOP) |-> (head_ff <= tail_ff) && (tail_ff < count_ff))
      else $error("search bounds out of order");
`endif

endmodule
